### sv/cln_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cln_pkg: shared types and constants of the character LCD nibble sequencer
// Request codes, power-up tables, the controller-to-datapath command and
// status structures, and the reciprocal used for the decimal digit split.
// ---------------------------------------------------------------------------
package cln_pkg;

  localparam int MAX_DIGITS_DEFAULT = 10;

  // Request codes.
  localparam logic [2:0] FUNC_INIT   = 3'd0;
  localparam logic [2:0] FUNC_CMD    = 3'd1;
  localparam logic [2:0] FUNC_DATA   = 3'd2;
  localparam logic [2:0] FUNC_CURSOR = 3'd3;
  localparam logic [2:0] FUNC_PRINT  = 3'd4;

  // Row base addresses of a 20x4 display.
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ROW3_BASE = 8'h94;
  localparam logic [7:0] ROW4_BASE = 8'hD4;

  // Waits in milliseconds.
  localparam logic [4:0] POWER_UP_WAIT_MS = 5'd20;
  localparam logic [2:0] CMD_WAIT_MS      = 3'd2;
  localparam logic [2:0] DATA_WAIT_MS     = 3'd1;

  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // ceil(2^35 / 10): floor(n * RECIP_DIV10 / 2^35) equals n / 10 for all
  // 32-bit n.
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic load;           // latch a new request
    logic idx_clr;
    logic idx_inc;
    logic emit_init_nib;  // one of the four power-up nibbles
    logic load_init_byte; // fetch an init command byte
    logic emit_hi;
    logic emit_lo;
    logic last;           // qualifies emit_lo
    logic mul;            // reciprocal product of the remaining number
    logic fix;            // store one digit, keep the quotient
    logic load_digit;     // fetch the next digit to print
  } cln_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_three;
    logic div_done;
  } cln_stat_t;

  function automatic logic [3:0] init_nib(input logic [1:0] idx);
    logic [3:0] val;
    unique case (idx)
      2'd3:    val = 4'h2;
      default: val = 4'h3;
    endcase
    return val;
  endfunction

  function automatic logic [2:0] init_nib_wait(input logic [1:0] idx);
    logic [2:0] val;
    unique case (idx)
      2'd0:    val = 3'd5;
      default: val = 3'd1;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h28; // function set: 4-bit bus, two lines
      2'd1:    val = 8'h0C; // display on, cursor off
      2'd2:    val = 8'h06; // entry mode: increment
      default: val = 8'h01; // clear display
    endcase
    return val;
  endfunction

  function automatic logic [2:0] init_byte_wait(input logic [1:0] idx);
    logic [2:0] val;
    unique case (idx)
      2'd3:    val = 3'd4;
      default: val = 3'd2;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

### sv/cln_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cln_dpath: datapath of the nibble sequencer
// Holds the request, the sequence index, the digit store and the result
// registers; splits numbers into decimal digits with a reciprocal multiply and a remainder step per digit.
// ---------------------------------------------------------------------------
module cln_dpath #(
  parameter int MAX_DIGITS = cln_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  cln_pkg::cln_cmd_t    cmd,
  output cln_pkg::cln_stat_t   stat,
  input  wire  [2:0]           func,
  input  wire  [7:0]           byte_value,
  input  wire  [2:0]           row,
  input  wire  [4:0]           column,
  input  wire  [31:0]          number,
  output logic                 strobe,
  output logic                 reg_select,
  output logic [3:0]           nibble,
  output logic [4:0]           wait_before_ms,
  output logic [2:0]           wait_after_ms,
  output logic                 last
);

  localparam int IDX_BITS = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W    = (IDX_BITS < 2) ? 2 : IDX_BITS;
  localparam int DIG_AW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic             rs;
  logic [7:0]       cur_byte;
  logic [2:0]       lo_wait;
  logic [31:0]      num;
  logic [63:0]      prod;
  logic [IDX_W-1:0] idx;
  logic [3:0]       digits [MAX_DIGITS];

  logic [7:0]       row_base;
  logic [7:0]       cursor_addr;
  logic [28:0]      quot;
  logic [31:0]      quot_x10;
  logic [31:0]      rem;
  logic [IDX_W-1:0] idx_prev;

  always_comb begin
    unique case (row)
      3'd1:    row_base = cln_pkg::ROW1_BASE;
      3'd2:    row_base = cln_pkg::ROW2_BASE;
      3'd3:    row_base = cln_pkg::ROW3_BASE;
      default: row_base = cln_pkg::ROW4_BASE;
    endcase
  end

  assign cursor_addr = row_base + {3'b000, column} - 8'd1;
  assign quot        = prod[63:cln_pkg::RECIP_SHIFT];
  assign quot_x10    = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem         = num - quot_x10;
  assign idx_prev    = idx - IDX_W'(1);

  assign stat.idx_zero  = (idx == '0);
  assign stat.idx_three = (idx == IDX_W'(3));
  assign stat.div_done  = (quot == '0) || (idx == IDX_W'(MAX_DIGITS - 1));

  // Request registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs       <= (func == cln_pkg::FUNC_DATA) || (func == cln_pkg::FUNC_PRINT);
      lo_wait  <= ((func == cln_pkg::FUNC_DATA) || (func == cln_pkg::FUNC_PRINT)) ?
                  cln_pkg::DATA_WAIT_MS : cln_pkg::CMD_WAIT_MS;
      cur_byte <= (func == cln_pkg::FUNC_CURSOR) ? cursor_addr : byte_value;
      num      <= number;
    end else if (cmd.load_init_byte) begin
      cur_byte <= cln_pkg::init_byte(idx[1:0]);
      lo_wait  <= cln_pkg::init_byte_wait(idx[1:0]);
    end else if (cmd.load_digit) begin
      cur_byte <= {cln_pkg::ASCII_DIGIT_HI, digits[idx_prev[DIG_AW-1:0]]};
    end else if (cmd.fix) begin
      num <= {3'b000, quot};
    end
    if (cmd.mul) begin
      prod <= 64'(num) * 64'(cln_pkg::RECIP_DIV10);
    end
    if (cmd.fix) begin
      digits[idx[DIG_AW-1:0]] <= rem[3:0];
    end
  end

  // Sequence index: init step, digit count, then digit read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc || cmd.fix) begin
      idx <= idx + IDX_W'(1);
    end else if (cmd.load_digit) begin
      idx <= idx_prev;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_init_nib || cmd.emit_hi || cmd.emit_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_init_nib) begin
      reg_select     <= 1'b0;
      nibble         <= cln_pkg::init_nib(idx[1:0]);
      wait_before_ms <= (idx == '0) ? cln_pkg::POWER_UP_WAIT_MS : 5'd0;
      wait_after_ms  <= cln_pkg::init_nib_wait(idx[1:0]);
      last           <= 1'b0;
    end else if (cmd.emit_hi) begin
      reg_select     <= rs;
      nibble         <= cur_byte[7:4];
      wait_before_ms <= 5'd0;
      wait_after_ms  <= 3'd0;
      last           <= 1'b0;
    end else if (cmd.emit_lo) begin
      reg_select     <= rs;
      nibble         <= cur_byte[3:0];
      wait_before_ms <= 5'd0;
      wait_after_ms  <= lo_wait;
      last           <= cmd.last;
    end
  end

endmodule
`default_nettype wire

### sv/cln_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cln_ctrl: controller of the nibble sequencer
// Steps through the transfers of one request and commands the datapath.
// ---------------------------------------------------------------------------
module cln_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire  [2:0]          func,
  input  cln_pkg::cln_stat_t  stat,
  output cln_pkg::cln_cmd_t   cmd,
  output logic                busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_INIT_LD = 3'd2;
  localparam logic [2:0] S_HI      = 3'd3;
  localparam logic [2:0] S_LO      = 3'd4;
  localparam logic [2:0] S_MUL     = 3'd5;
  localparam logic [2:0] S_FIX     = 3'd6;
  localparam logic [2:0] S_DIG_LD  = 3'd7;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_INIT   = 2'd1;
  localparam logic [1:0] MODE_PRINT  = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] mode, mode_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          unique case (func) inside
            cln_pkg::FUNC_INIT: begin
              mode_next  = MODE_INIT;
              state_next = S_INIT;
            end
            cln_pkg::FUNC_CMD, cln_pkg::FUNC_DATA, cln_pkg::FUNC_CURSOR: begin
              mode_next  = MODE_SINGLE;
              state_next = S_HI;
            end
            cln_pkg::FUNC_PRINT: begin
              mode_next  = MODE_PRINT;
              state_next = S_MUL;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        cmd.emit_init_nib = 1'b1;
        if (stat.idx_three) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_INIT_LD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_INIT_LD: begin
        cmd.load_init_byte = 1'b1;
        state_next         = S_HI;
      end
      S_HI: begin
        cmd.emit_hi = 1'b1;
        state_next  = S_LO;
      end
      S_LO: begin
        cmd.emit_lo = 1'b1;
        unique case (mode)
          MODE_INIT: begin
            if (stat.idx_three) begin
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_INIT_LD;
            end
          end
          MODE_PRINT: begin
            if (stat.idx_zero) begin
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_DIG_LD;
            end
          end
          default: begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = stat.div_done ? S_DIG_LD : S_MUL;
      end
      S_DIG_LD: begin
        cmd.load_digit = 1'b1;
        state_next     = S_HI;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_SINGLE;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

endmodule
`default_nettype wire

### sv/char_lcd_nibble_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core: HD44780 4-bit transfer sequencer
// Turns init, command, data, set-cursor and print-number requests into the
// nibble transfers of a 20x4 character display.
// ---------------------------------------------------------------------------
// A request transaction is taken on a clock edge where start is high and busy
// is low; busy then stays high until the request's last transfer has been
// issued. Each transfer appears on the result ports for exactly one cycle,
// flagged by strobe, and cannot be held off, so the receiver must take it on
// that cycle (typically into a FIFO in front of the slow enable-pulse timer).
// Transfers of one request come at most one per cycle. A command, data or
// set-cursor request issues its byte as two nibbles; init issues four
// power-up nibbles, then one fetch and two nibbles per command byte. Print
// number splits the number into decimal digits, each by a reciprocal
// multiply and a remainder step, then issues the digits most significant
// first, each as a fetch and two nibbles, up to MAX_DIGITS digits. The
// last transfer of a request carries last; a new request may be taken in
// the cycle where that transfer is shown. Function codes 5 to 7 are taken
// and give no transfers. Rows other than 1 to 3 address row 4, and the
// cursor address wraps modulo 256.
// ---------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core #(
  parameter int MAX_DIGITS = cln_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  func,
  input  wire  [7:0]  byte_value,
  input  wire  [2:0]  row,
  input  wire  [4:0]  column,
  input  wire  [31:0] number,
  output logic        strobe,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic [4:0]  wait_before_ms,
  output logic [2:0]  wait_after_ms,
  output logic        last
);

  cln_pkg::cln_cmd_t  cmd;
  cln_pkg::cln_stat_t stat;

  cln_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cln_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .byte_value     (byte_value),
    .row            (row),
    .column         (column),
    .number         (number),
    .strobe         (strobe),
    .reg_select     (reg_select),
    .nibble         (nibble),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

  // A valid request always produces work on the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func <= cln_pkg::FUNC_PRINT) |=> busy)
    else $error("valid request did not make the sequencer busy");

  // Every transfer stems from a busy cycle.
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("transfer issued while idle");

  // The final transfer frees the sequencer.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("sequencer still busy after the final transfer");

  // Only the first power-up nibble carries a wait before its pulse.
  a_wait_before: assert property (@(posedge clk) disable iff (rst)
    (strobe && wait_before_ms != 5'd0) |-> (nibble == 4'h3 && !reg_select && !last))
    else $error("unexpected wait before a transfer");

endmodule
`default_nettype wire

### tb/char_lcd_nibble_sequencer_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_test: self-checking bench of the LCD sequencer
// Drives init, command, data, set-cursor and print-number requests through
// the start/busy handshake, expands each accepted request into the nibble
// transfers it must produce, and compares every strobed transfer field by
// field against the oldest transfer still expected.
// ---------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_test;

  // Function codes 5 to 7 have no meaning; the block takes them and stays quiet.
  localparam logic [2:0] FUNC_UNUSED_LO  = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_MID = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI  = 3'd7;

  // Power-up command bytes and the longer settle time after a clear.
  localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CLEAR_DISPLAY    = 8'h01;
  localparam logic [2:0] CLEAR_WAIT_MS    = 3'd4;
  localparam logic [3:0] WAKE_NIB         = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB     = 4'h2;
  localparam logic [2:0] WAKE_FIRST_MS    = 3'd5;
  localparam logic [2:0] WAKE_NEXT_MS     = 3'd1;

  localparam int NUM_DIRECTED   = 25;
  localparam int NUM_PHASES     = 4;
  localparam int ITEMS_PER_PHASE = 60;
  // A print of ten digits is the longest request, and a sender gap at 52
  // percent is rarely long. The limit is far beyond both together.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet time after the last expected transfer, to catch stray strobes.
  localparam int SETTLE_CYCLES  = 64;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  byte_value;
    logic [2:0]  row;
    logic [4:0]  column;
    logic [31:0] number;
  } lcd_req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [4:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       last;
  } lcd_xfer_t;

  // One row of the directed table. Where typed is set, the row's transfers
  // are the single byte given by rs/code/wa (or nothing when silent) rather
  // than the output of the transfer predictor.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  bval;
    logic [2:0]  row;
    logic [4:0]  col;
    logic [31:0] num;
    bit          typed;
    bit          silent;
    logic        rs;
    logic [7:0]  code;
    logic [2:0]  wa;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = '0;
  logic [7:0]  byte_value = '0;
  logic [2:0]  row = '0;
  logic [4:0]  column = '0;
  logic [31:0] number = '0;
  logic        strobe;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [4:0]  wait_before_ms;
  logic [2:0]  wait_after_ms;
  logic        last;

  // Transfers predicted for accepted requests, oldest first.
  lcd_xfer_t pending_xfers[$];
  lcd_xfer_t head_xfer;
  int        err_count = 0;
  int        quiet_cycles = 0;

  // Sender gap probability per random phase. The receiver cannot hold off
  // transfers, so the phases that would stall it run with a steady sender.
  int unsigned gap_pct [NUM_PHASES] = '{0, 52, 0, 36};

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // Full power-up sequence straight after reset.
    '{cln_pkg::FUNC_INIT,   8'h00, 3'd1, 5'd1,  32'd0,
      1'b0, 1'b0, 1'b0, 8'h00, 3'd0},
    // Command and data bytes at the extremes of the byte.
    '{cln_pkg::FUNC_CMD,    8'h00, 3'd0, 5'd0,  32'd0,
      1'b1, 1'b0, 1'b0, 8'h00, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CMD,    8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF,
      1'b1, 1'b0, 1'b0, 8'hFF, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_DATA,   8'h00, 3'd0, 5'd0,  32'd0,
      1'b1, 1'b0, 1'b1, 8'h00, cln_pkg::DATA_WAIT_MS},
    '{cln_pkg::FUNC_DATA,   8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF,
      1'b1, 1'b0, 1'b1, 8'hFF, cln_pkg::DATA_WAIT_MS},
    '{cln_pkg::FUNC_DATA,   8'hA5, 3'd2, 5'd10, 32'd5,
      1'b1, 1'b0, 1'b1, 8'hA5, cln_pkg::DATA_WAIT_MS},
    // Cursor at one end of every row.
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd1, 5'd1,  32'd0,
      1'b1, 1'b0, 1'b0, 8'h80, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd2, 5'd20, 32'd0,
      1'b1, 1'b0, 1'b0, 8'hD3, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd3, 5'd1,  32'd0,
      1'b1, 1'b0, 1'b0, 8'h94, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd4, 5'd20, 32'd0,
      1'b1, 1'b0, 1'b0, 8'hE7, cln_pkg::CMD_WAIT_MS},
    // Rows outside 1..3 fall back to the row 4 base; odd columns just add.
    '{cln_pkg::FUNC_CURSOR, 8'hFF, 3'd0, 5'd1,  32'd0,
      1'b1, 1'b0, 1'b0, 8'hD4, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'hFF, 3'd7, 5'd31, 32'd0,
      1'b1, 1'b0, 1'b0, 8'hF2, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd5, 5'd0,  32'd0,
      1'b1, 1'b0, 1'b0, 8'hD3, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd1, 5'd0,  32'd0,
      1'b1, 1'b0, 1'b0, 8'h7F, cln_pkg::CMD_WAIT_MS},
    '{cln_pkg::FUNC_CURSOR, 8'h00, 3'd2, 5'd31, 32'd0,
      1'b1, 1'b0, 1'b0, 8'hDE, cln_pkg::CMD_WAIT_MS},
    // Zero prints as a single '0'; single digits are one byte.
    '{cln_pkg::FUNC_PRINT,  8'h00, 3'd0, 5'd0,  32'd0,
      1'b1, 1'b0, 1'b1, 8'h30, cln_pkg::DATA_WAIT_MS},
    '{cln_pkg::FUNC_PRINT,  8'h00, 3'd0, 5'd0,  32'd9,
      1'b1, 1'b0, 1'b1, 8'h39, cln_pkg::DATA_WAIT_MS},
    '{cln_pkg::FUNC_PRINT,  8'h00, 3'd0, 5'd0,  32'd10,
      1'b0, 1'b0, 1'b0, 8'h00, 3'd0},
    '{cln_pkg::FUNC_PRINT,  8'h00, 3'd0, 5'd0,  32'hFFFF_FFFF,
      1'b0, 1'b0, 1'b0, 8'h00, 3'd0},
    '{cln_pkg::FUNC_PRINT,  8'h00, 3'd0, 5'd0,  32'd1000000000,
      1'b0, 1'b0, 1'b0, 8'h00, 3'd0},
    // Unused function codes: taken, nothing comes out.
    '{FUNC_UNUSED_LO,  8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF,
      1'b1, 1'b1, 1'b0, 8'h00, 3'd0},
    '{FUNC_UNUSED_MID, 8'h00, 3'd0, 5'd0,  32'd0, 1'b1, 1'b1, 1'b0, 8'h00, 3'd0},
    '{FUNC_UNUSED_HI,  8'h55, 3'd3, 5'd7,  32'd77, 1'b1, 1'b1, 1'b0, 8'h00, 3'd0},
    // A second power-up in the middle of traffic, then a plain command.
    '{cln_pkg::FUNC_INIT,   8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF,
      1'b0, 1'b0, 1'b0, 8'h00, 3'd0},
    '{cln_pkg::FUNC_CMD,    8'h5A, 3'd1, 5'd1,  32'd0,
      1'b0, 1'b0, 1'b0, 8'h00, 3'd0}
  };

  char_lcd_nibble_sequencer_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .byte_value     (byte_value),
    .row            (row),
    .column         (column),
    .number         (number),
    .strobe         (strobe),
    .reg_select     (reg_select),
    .nibble         (nibble),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic lcd_xfer_t xfer(input logic rs, input logic [3:0] nib,
                                     input logic [4:0] wb, input logic [2:0] wa,
                                     input logic fin);
    lcd_xfer_t x;
    x.reg_select     = rs;
    x.nibble         = nib;
    x.wait_before_ms = wb;
    x.wait_after_ms  = wa;
    x.last           = fin;
    return x;
  endfunction

  // A byte goes out high nibble first; only the low nibble carries the pause
  // and, when the byte ends the request, the last flag.
  task automatic push_byte(input logic rs, input logic [7:0] code,
                           input logic [2:0] wa, input logic fin);
    pending_xfers.push_back(xfer(rs, code[7:4], 5'd0, 3'd0, 1'b0));
    pending_xfers.push_back(xfer(rs, code[3:0], 5'd0, wa, fin));
  endtask

  // Transfer predictor: appends every transfer an accepted request must cause.
  task automatic expand_request(input lcd_req_t r);
    logic [7:0]  base;
    logic [7:0]  addr;
    logic [31:0] rest;
    logic [3:0]  digits [cln_pkg::MAX_DIGITS_DEFAULT];
    int          nd;
    case (r.func)
      cln_pkg::FUNC_INIT: begin
        // Three wake-up nibbles and the switch to 4-bit mode come before any
        // full byte, the first of them after the power-up wait.
        pending_xfers.push_back(xfer(1'b0, WAKE_NIB, cln_pkg::POWER_UP_WAIT_MS,
                                     WAKE_FIRST_MS, 1'b0));
        pending_xfers.push_back(xfer(1'b0, WAKE_NIB, 5'd0, WAKE_NEXT_MS, 1'b0));
        pending_xfers.push_back(xfer(1'b0, WAKE_NIB, 5'd0, WAKE_NEXT_MS, 1'b0));
        pending_xfers.push_back(xfer(1'b0, FOUR_BIT_NIB, 5'd0, WAKE_NEXT_MS, 1'b0));
        push_byte(1'b0, LCD_FUNCTION_SET, cln_pkg::CMD_WAIT_MS, 1'b0);
        push_byte(1'b0, LCD_DISPLAY_ON, cln_pkg::CMD_WAIT_MS, 1'b0);
        push_byte(1'b0, LCD_ENTRY_MODE, cln_pkg::CMD_WAIT_MS, 1'b0);
        push_byte(1'b0, CLEAR_DISPLAY, CLEAR_WAIT_MS, 1'b1);
      end
      cln_pkg::FUNC_CMD:  push_byte(1'b0, r.byte_value, cln_pkg::CMD_WAIT_MS, 1'b1);
      cln_pkg::FUNC_DATA: push_byte(1'b1, r.byte_value, cln_pkg::DATA_WAIT_MS, 1'b1);
      cln_pkg::FUNC_CURSOR: begin
        case (r.row)
          3'd1:    base = cln_pkg::ROW1_BASE;
          3'd2:    base = cln_pkg::ROW2_BASE;
          3'd3:    base = cln_pkg::ROW3_BASE;
          default: base = cln_pkg::ROW4_BASE;
        endcase
        addr = base + {3'b000, r.column} - 8'd1;
        push_byte(1'b0, addr, cln_pkg::CMD_WAIT_MS, 1'b1);
      end
      cln_pkg::FUNC_PRINT: begin
        rest = r.number;
        nd = 0;
        if (rest == 32'd0) begin
          digits[0] = 4'd0;
          nd = 1;
        end else begin
          while (rest != 32'd0 && nd < cln_pkg::MAX_DIGITS_DEFAULT) begin
            digits[nd] = 4'(rest % 32'd10);
            rest = rest / 32'd10;
            nd++;
          end
        end
        for (int i = nd - 1; i >= 0; i--)
          push_byte(1'b1, {cln_pkg::ASCII_DIGIT_HI, digits[i]}, cln_pkg::DATA_WAIT_MS,
                    i == 0);
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] p10;
    int          pick;
    pick = $urandom_range(99);
    p10 = 32'd1;
    if (pick < 25) return 32'($urandom_range(9));
    if (pick < 50) return 32'($urandom_range(99999));
    if (pick < 70) begin
      // Just below and at a power of ten, where the digit count changes.
      repeat ($urandom_range(1, 9)) p10 = p10 * 32'd10;
      return p10 - 32'($urandom_range(1));
    end
    if (pick < 75) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int       pick;
    pick = $urandom_range(99);
    r.byte_value = 8'($urandom);
    r.row        = ($urandom_range(99) < 80) ? 3'($urandom_range(1, 4)) : 3'($urandom);
    r.column     = ($urandom_range(99) < 80) ? 5'($urandom_range(1, 20)) : 5'($urandom);
    r.number     = $urandom;
    if (pick < 4)       r.func = cln_pkg::FUNC_INIT;
    else if (pick < 24) r.func = cln_pkg::FUNC_CMD;
    else if (pick < 46) r.func = cln_pkg::FUNC_DATA;
    else if (pick < 66) r.func = cln_pkg::FUNC_CURSOR;
    else if (pick < 90) begin
      r.func   = cln_pkg::FUNC_PRINT;
      r.number = random_number();
    end else            r.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    return r;
  endfunction

  // Presents one request and returns in the time step of the edge that took
  // it. While the sender idles, start is low and the request fields carry
  // junk that the block must ignore.
  task automatic issue(input lcd_req_t r, input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start      <= 1'b0;
      func       <= 3'($urandom);
      byte_value <= 8'($urandom);
      row        <= 3'($urandom);
      column     <= 5'($urandom);
      number     <= $urandom;
      @(posedge clk);
    end
    start      <= 1'b1;
    func       <= r.func;
    byte_value <= r.byte_value;
    row        <= r.row;
    column     <= r.column;
    number     <= r.number;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Holds the sender back until the block is idle and every transfer it
  // owes has been seen.
  task automatic drain();
    start <= 1'b0;
    while (pending_xfers.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Stimulus: reset, the directed table, then random phases with a full
  // drain between phases.
  initial begin : stimulus
    lcd_req_t r;
    dir_row_t d;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      d = directed_rows[i];
      r = '{d.func, d.bval, d.row, d.col, d.num};
      issue(r, 0);
      if (!d.typed)
        expand_request(r);
      else if (!d.silent)
        push_byte(d.rs, d.code, d.wa, 1'b1);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = random_request();
        issue(r, gap_pct[p]);
        expand_request(r);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Transfer checker and watchdog. A transfer is valid for exactly the cycle
  // its strobe is high and is taken at the edge that ends that cycle. The
  // watchdog counts cycles in which neither a request nor a transfer moves.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (strobe === 1'b1) begin
        if (pending_xfers.size() == 0) begin
          $error("unexpected transfer: rs %0b nibble %0h before %0d after %0d last %0b",
                 reg_select, nibble, wait_before_ms, wait_after_ms, last);
          err_count++;
        end else begin
          head_xfer = pending_xfers.pop_front();
          if (reg_select !== head_xfer.reg_select) begin
            $error("reg_select: expected %0b, got %0b", head_xfer.reg_select, reg_select);
            err_count++;
          end
          if (nibble !== head_xfer.nibble) begin
            $error("nibble: expected %0h, got %0h", head_xfer.nibble, nibble);
            err_count++;
          end
          if (wait_before_ms !== head_xfer.wait_before_ms) begin
            $error("wait_before_ms: expected %0d, got %0d",
                   head_xfer.wait_before_ms, wait_before_ms);
            err_count++;
          end
          if (wait_after_ms !== head_xfer.wait_after_ms) begin
            $error("wait_after_ms: expected %0d, got %0d",
                   head_xfer.wait_after_ms, wait_after_ms);
            err_count++;
          end
          if (last !== head_xfer.last) begin
            $error("last: expected %0b, got %0b", head_xfer.last, last);
            err_count++;
          end
        end
      end
      if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
